### rtl/core/assert_macros.svh
// Assertion macros used by the checker file pwsp_checker.sv.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion failed");

// ante implies cons on the same edge
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/pwsp_pkg.sv
// Package for the plane-wave surface point block: types, constants, helpers.
// No dependencies.
package pwsp_pkg;

   localparam int XY_W = 34;
   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   localparam logic [7:0] REG_AMPLITUDE = 8'd0;
   localparam logic [7:0] REG_WAVE_ANGLE = 8'd1;
   localparam logic [7:0] REG_WAVE_PHASE = 8'd2;
   localparam logic [7:0] REG_WAVE_FREQUENCY = 8'd3;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [XY_W-1:0] z;
      logic neg;
   } cordic_vec_type;

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] bz;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } item_type;

   typedef struct packed {
      logic signed [31:0] bz;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } side_type;

   // arctangent steps in 2^-32 turn units
   function automatic logic [31:0] atan_step(input int idx);
      logic [31:0] r;
      case (idx)
         0: r = 32'd536870912;
         1: r = 32'd316933406;
         2: r = 32'd167458907;
         3: r = 32'd85004756;
         4: r = 32'd42667331;
         5: r = 32'd21354465;
         6: r = 32'd10679838;
         7: r = 32'd5340245;
         8: r = 32'd2670163;
         9: r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/pwsp_cordic_cell.sv
// One registered CORDIC rotation step.
// Depends on pwsp_pkg.
module pwsp_cordic_cell import pwsp_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic           clock,
   input  cordic_vec_type cell_din,
   output cordic_vec_type cell_dout
);

   localparam logic signed [XY_W-1:0] ATAN = XY_W'(signed'({1'b0, atan_step(IDX)}));

   cordic_vec_type vec_in;
   cordic_vec_type vec_ff;

   always_comb begin
      vec_in = cell_din;
      if (!cell_din.z[XY_W-1]) begin
         vec_in.x = cell_din.x - (cell_din.y >>> IDX);
         vec_in.y = cell_din.y + (cell_din.x >>> IDX);
         vec_in.z = cell_din.z - ATAN;
      end else begin
         vec_in.x = cell_din.x + (cell_din.y >>> IDX);
         vec_in.y = cell_din.y - (cell_din.x >>> IDX);
         vec_in.z = cell_din.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign cell_dout = vec_ff;

endmodule

### rtl/core/pwsp_cordic_chain.sv
// Pipelined cosine/sine of a 32-bit binary angle: quadrant fold, row of cells, rounding.
// Depends on pwsp_pkg and pwsp_cordic_cell.
module pwsp_cordic_chain import pwsp_pkg::*; #(
   parameter int STAGES = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic [31:0]                 angle,
   output logic signed [FRAC_BITS+2:0] cos_out,
   output logic signed [FRAC_BITS+2:0] sin_out
);

   localparam int CW = FRAC_BITS + 3;
   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [XY_W-1:0] HALF = XY_W'(1) <<< (SH - 1);

   cordic_vec_type pre_in, pre_ff;
   cordic_vec_type vec [0:STAGES];
   logic signed [XY_W-1:0] xn, yn, xr, yr;
   logic signed [CW-1:0] cos_in, sin_in, cos_ff, sin_ff;
   logic [31:0] folded;
   logic neg;

   always_comb begin
      neg = |((angle + QUARTER_TURN) & HALF_TURN);
      folded = neg ? (angle - HALF_TURN) : angle;
      pre_in.x = GAIN_Q30;
      pre_in.y = '0;
      pre_in.z = XY_W'(signed'(folded));
      pre_in.neg = neg;
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign vec[0] = pre_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      pwsp_cordic_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .cell_din  (vec[i]),
         .cell_dout (vec[i+1])
      );
   end

   always_comb begin
      xn = vec[STAGES].neg ? -vec[STAGES].x : vec[STAGES].x;
      yn = vec[STAGES].neg ? -vec[STAGES].y : vec[STAGES].y;
      xr = (xn + HALF) >>> SH;
      yr = (yn + HALF) >>> SH;
      cos_in = xr[CW-1:0];
      sin_in = yr[CW-1:0];
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### rtl/core/plane_wave_surface_point_top.sv
// Plane-wave surface point: top level with register file and arithmetic pipeline.
// Depends on pwsp_pkg and pwsp_cordic_chain.
// One request per cycle, busy is never raised. Each request produces one result on the
// rsp_ ports, marked by rsp_valid for one cycle, after passing two CORDIC cell rows in series
// plus five arithmetic stages. The receiver cannot stall; results must be taken when rsp_valid
// is high. Registers are written through the csr_ port, which is always ready; the user must
// write them only while no request is in flight, which the block itself does not enforce.
module plane_wave_surface_point_top import pwsp_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_u_pos,
   input  logic signed [31:0] req_v_pos,
   input  logic signed [31:0] req_base_x,
   input  logic signed [31:0] req_base_y,
   input  logic signed [31:0] req_base_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int L = N + 2;
   localparam int LAST = 2 * L + 4;
   localparam int CW = FRAC_BITS + 3;
   localparam int P1 = 32 + CW;
   localparam int SW = P1 + 1 - FRAC_BITS;
   localparam int PW = 32 + SW;
   localparam int DW = CW + 1;
   localparam int P2 = 32 + DW;
   localparam logic signed [P1:0] HALF1 = (P1+1)'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [P2-1:0] HALF2 = P2'(1) <<< (FRAC_BITS - 1);

   logic signed [31:0] amp_ff, freq_ff;
   logic [15:0] angle_ff, phase_ff;
   logic [LAST:0] vld_ff;
   logic accept;

   item_type item_in;
   item_type a_ff [0:L-1];
   logic signed [CW-1:0] cw, sw, cph, cwave;

   logic signed [P1-1:0] pu_ff, pv_ff;
   side_type m1_side_ff, m2_side_ff;
   logic signed [CW-1:0] m1_cph_ff, m2_cph_ff;
   logic signed [P1:0] sum_w;
   logic signed [SW-1:0] s_in, s_ff;
   logic signed [PW-1:0] prod;
   logic [31:0] ang_in, ang_ff;
   side_type q_side_ff [0:L];
   logic signed [CW-1:0] q_cph_ff [0:L];
   logic signed [DW-1:0] diff;
   logic signed [P2-1:0] prod2_ff, bump;
   side_type m4_side_ff;
   logic signed [31:0] z_in, x_ff, y_ff, z_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '0;
         freq_ff <= '0;
         angle_ff <= '0;
         phase_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_AMPLITUDE: amp_ff <= csr_data;
            REG_WAVE_ANGLE: angle_ff <= csr_data[15:0];
            REG_WAVE_PHASE: phase_ff <= csr_data[15:0];
            REG_WAVE_FREQUENCY: freq_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAST-1:0], accept};
      end
   end

   pwsp_cordic_chain #(.STAGES(N), .FRAC_BITS(FRAC_BITS)) u_dir (
      .clock   (clock),
      .angle   ({angle_ff, 16'h0000}),
      .cos_out (cw),
      .sin_out (sw)
   );

   pwsp_cordic_chain #(.STAGES(N), .FRAC_BITS(FRAC_BITS)) u_phase (
      .clock   (clock),
      .angle   ({phase_ff, 16'h0000}),
      .cos_out (cph),
      .sin_out ()
   );

   always_comb begin
      item_in.u = req_u_pos;
      item_in.v = req_v_pos;
      item_in.bz = req_base_z;
      item_in.px = sat32(64'(req_u_pos) + 64'(req_base_x));
      item_in.py = sat32(64'(req_v_pos) + 64'(req_base_y));
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= item_in;
      for (int k = 1; k < L; k++) begin
         a_ff[k] <= a_ff[k-1];
      end
   end

   // projection s = u*cos + v*sin
   always_ff @(posedge clock) begin
      pu_ff <= P1'(a_ff[L-1].u) * P1'(cw);
      pv_ff <= P1'(a_ff[L-1].v) * P1'(sw);
      m1_side_ff <= '{bz: a_ff[L-1].bz, px: a_ff[L-1].px, py: a_ff[L-1].py};
      m1_cph_ff <= cph;
   end

   always_comb begin
      sum_w = (P1+1)'(pu_ff) + (P1+1)'(pv_ff) + HALF1;
      s_in = SW'(sum_w >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      m2_side_ff <= m1_side_ff;
      m2_cph_ff <= m1_cph_ff;
   end

   // wave angle from f*s plus the wave phase
   always_comb begin
      prod = PW'(freq_ff) * PW'(s_ff);
      ang_in = prod[2*FRAC_BITS+15 -: 32] + {phase_ff, 16'h0000};
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
      q_side_ff[0] <= m2_side_ff;
      q_cph_ff[0] <= m2_cph_ff;
      for (int k = 1; k <= L; k++) begin
         q_side_ff[k] <= q_side_ff[k-1];
         q_cph_ff[k] <= q_cph_ff[k-1];
      end
   end

   pwsp_cordic_chain #(.STAGES(N), .FRAC_BITS(FRAC_BITS)) u_wave (
      .clock   (clock),
      .angle   (ang_ff),
      .cos_out (cwave),
      .sin_out ()
   );

   assign diff = DW'(cwave) - DW'(q_cph_ff[L]);

   always_ff @(posedge clock) begin
      prod2_ff <= P2'(amp_ff) * P2'(diff);
      m4_side_ff <= q_side_ff[L];
   end

   always_comb begin
      bump = (prod2_ff + HALF2) >>> FRAC_BITS;
      z_in = sat32(64'(bump) + 64'(m4_side_ff.bz));
   end

   always_ff @(posedge clock) begin
      x_ff <= m4_side_ff.px;
      y_ff <= m4_side_ff.py;
      z_ff <= z_in;
   end

   assign rsp_valid = vld_ff[LAST];
   assign rsp_point_x = x_ff;
   assign rsp_point_y = y_ff;
   assign rsp_point_z = z_ff;

endmodule

### rtl/core/pwsp_checker.sv
// Port-level checker for plane_wave_surface_point_top, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pwsp_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_u_pos,
   input logic [31:0] req_base_x,
   input logic        rsp_valid,
   input logic [31:0] rsp_point_x
);

   localparam int N = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
   localparam int LAT = 2 * (N + 2) + 5;

   logic [31:0] x_sum;
   logic x_sat;

   assign x_sum = req_u_pos + req_base_x;
   assign x_sat = (rsp_point_x == 32'h7fff_ffff) || (rsp_point_x == 32'h8000_0000);

   `ASSERT_NEVER(a_busy_low, busy)
   `ASSERT_IMPLY(a_rsp_has_request, rsp_valid, $past(start, LAT))
   `ASSERT_IMPLY(a_x_sum, rsp_valid, (rsp_point_x == $past(x_sum, LAT)) || x_sat)
   `ASSERT_IMPLY(a_request_answered, start, ##LAT rsp_valid)

endmodule

bind plane_wave_surface_point_top pwsp_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_pwsp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_u_pos   (req_u_pos),
   .req_base_x  (req_base_x),
   .rsp_valid   (rsp_valid),
   .rsp_point_x (rsp_point_x)
);
